@@ rtl/arat_pkg.sv @@
// ----------------------------------------------------------------------------
// arat_pkg
// Shared types and constants for the address range alias table.
// ----------------------------------------------------------------------------
package arat_pkg;

    localparam int ENTRIES = 4096;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int ENT_W   = 96;

    localparam logic [2:0] OP_RESOLVE = 3'd0;
    localparam logic [2:0] OP_ADD     = 3'd1;
    localparam logic [2:0] OP_REMOVE  = 3'd2;
    localparam logic [2:0] OP_CLEAR   = 3'd3;
    localparam logic [2:0] OP_GET     = 3'd4;

    localparam logic [0:0] REG_MEM_BASE  = 1'd0;
    localparam logic [0:0] REG_MEM_BYTES = 1'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_FLAG,
        S_OUT
    } t_state;

    // Does [start, start+size) overlap [base, base+bytes)? 33-bit ends.
    function automatic logic touches(input logic [31:0] start, input logic [31:0] size,
                                     input logic [31:0] base, input logic [31:0] bytes);
        logic [32:0] e;
        logic [32:0] me;
        e  = {1'b0, start} + {1'b0, size};
        me = {1'b0, base} + {1'b0, bytes};
        return ({1'b0, start} < me) && (e > {1'b0, base});
    endfunction

endpackage

@@ rtl/arat_ram.sv @@
// ----------------------------------------------------------------------------
// arat_ram
// Generic single-port write, single-port read RAM with registered read.
// ----------------------------------------------------------------------------
module arat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ rtl/address_range_alias_table.sv @@
// ----------------------------------------------------------------------------
// address_range_alias_table
// Table of guest address ranges with resolve, add, remove, clear and get.
// ----------------------------------------------------------------------------
// Usage:
//   One command beat on s_axis (tdata = op, guest_addr, length, host_base)
//   gives one result beat on m_axis (tdata = ok, host_addr, ram_offset,
//   touches_main_mem, generation, entry_count). Commands are handled one at a
//   time; s_axis_tready is high only while the block is idle and no result
//   beat is waiting, so a new command is taken after the result is drained.
//   Entries live in one RAM (start, size, host base per word) read one word
//   per cycle with registered read data, so timing follows table walks:
//     add, clear, unknown op : handled without a table walk
//     resolve, get           : linear scan over the entries
//     remove                 : scan to match k, shift later entries down,
//                              then rescan all to rebuild the main-mem flag
//   Reset (synchronous, i_rst_n low) empties the table, clears the flag and
//   generation, and loads the main memory window registers. RAM contents are
//   not cleared; only entries below the count are ever read.
//   When m_axis_tready is low the result is held and no new command is taken.
//   Configuration writes (i_cfg_we/i_cfg_index/i_cfg_data) are taken any time
//   but are meant for idle periods; they do not re-evaluate the flag.
// ----------------------------------------------------------------------------
module address_range_alias_table (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [0:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // op[2:0], guest_addr[34:3], length[66:35], host_base[98:67], pad
    input  logic [103:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // ok[0], host_addr[32:1], ram_offset[64:33], touches_main_mem[65],
    // generation[97:66], entry_count[110:98], pad
    output logic [111:0] m_axis_tdata
);
    localparam int IW = arat_pkg::IDX_W;
    localparam int CW = arat_pkg::CNT_W;

    arat_pkg::t_state r_state, n_state;

    logic [31:0]   r_base, r_bytes;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_flag, n_flag;
    logic [31:0]   r_gen, n_gen;
    logic [2:0]    r_op;
    logic [31:0]   r_addr, r_len, r_hb;
    logic [CW-1:0] r_i, n_i;
    logic          r_rv, n_rv;       // read data valid next cycle
    logic [IW-1:0] r_ri, n_ri;       // index of entry in read data; write target in S_SHIFT
    logic          r_ok, n_ok;
    logic [31:0]   r_host, n_host, r_roff, n_roff;
    logic          r_ov, n_ov;

    logic            we;
    logic [IW-1:0]   waddr, raddr;
    logic [95:0]     wdata, rdata;
    logic [31:0]     rs, rz, rh, off;

    arat_ram #(.WIDTH(arat_pkg::ENT_W), .DEPTH(arat_pkg::ENTRIES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign rs  = rdata[31:0];
    assign rz  = rdata[63:32];
    assign rh  = rdata[95:64];
    assign off = r_addr - rs;

    assign s_axis_tready = (r_state == arat_pkg::S_IDLE) && !r_ov;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {1'b0, r_cnt, r_gen, r_flag, r_roff, r_host, r_ok};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= 32'h8000_0000;
            r_bytes <= 32'd25165824;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                arat_pkg::REG_MEM_BASE:  r_base  <= i_cfg_data;
                arat_pkg::REG_MEM_BYTES: r_bytes <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= arat_pkg::S_IDLE;
            r_cnt   <= '0;
            r_flag  <= 1'b0;
            r_gen   <= '0;
            r_ov    <= 1'b0;
            r_rv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_flag  <= n_flag;
            r_gen   <= n_gen;
            r_ov    <= n_ov;
            r_rv    <= n_rv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_op   <= s_axis_tdata[2:0];
            r_addr <= s_axis_tdata[34:3];
            r_len  <= s_axis_tdata[66:35];
            r_hb   <= s_axis_tdata[98:67];
        end
        r_i    <= n_i;
        r_ri   <= n_ri;
        r_ok   <= n_ok;
        r_host <= n_host;
        r_roff <= n_roff;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_flag  = r_flag;
        n_gen   = r_gen;
        n_ov    = r_ov && !m_axis_tready;
        n_i     = r_i;
        n_rv    = 1'b0;
        n_ri    = r_i[IW-1:0];
        n_ok    = r_ok;
        n_host  = r_host;
        n_roff  = r_roff;
        we      = 1'b0;
        waddr   = r_cnt[IW-1:0];
        wdata   = {r_hb, r_len, r_addr};
        raddr   = r_i[IW-1:0];
        unique case (r_state)
            arat_pkg::S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    n_state = arat_pkg::S_OUT;
                    n_ok = 1'b0;
                    n_host = '0;
                    n_roff = '0;
                    n_i = '0;
                    case (s_axis_tdata[2:0]) inside
                        arat_pkg::OP_RESOLVE, arat_pkg::OP_GET,
                        arat_pkg::OP_REMOVE: n_state = arat_pkg::S_SCAN;
                        default: ;
                    endcase
                end
            end
            arat_pkg::S_OUT: begin
                // ops without a table scan are executed here
                case (r_op)
                    arat_pkg::OP_ADD: begin
                        if (r_len != 0 && r_hb != 0 && r_cnt < CW'(arat_pkg::ENTRIES)) begin
                            we = 1'b1;
                            n_cnt = r_cnt + 1'b1;
                            n_ok = 1'b1;
                            if (arat_pkg::touches(r_addr, r_len, r_base, r_bytes)) begin
                                n_flag = 1'b1;
                                n_gen = r_gen + 1'b1;
                            end
                        end
                    end
                    arat_pkg::OP_CLEAR: begin
                        n_cnt = '0;
                        n_flag = 1'b0;
                        n_gen = r_gen + 1'b1;
                        n_ok = 1'b1;
                    end
                    default: ;
                endcase
                n_ov = 1'b1;
                n_state = arat_pkg::S_IDLE;
            end
            arat_pkg::S_SCAN: begin
                // issue read of entry r_i; check returned entry r_ri
                logic hit;
                hit = 1'b0;
                if (r_rv) begin
                    if (r_op == arat_pkg::OP_RESOLVE) begin
                        hit = r_len != 0 && !(r_addr < rs || r_len > rz || off > rz - r_len);
                    end else begin
                        hit = rs == r_addr && rz == r_len;
                    end
                end
                if (hit) begin
                    if (r_op == arat_pkg::OP_REMOVE) begin
                        n_state = arat_pkg::S_SHIFT;
                        n_i = {1'b0, r_ri} + 1'b1;
                    end else begin
                        n_ok = 1'b1;
                        if (r_op == arat_pkg::OP_RESOLVE) begin
                            n_host = rh + off;
                            n_roff = r_addr - r_base;
                        end else begin
                            n_host = rh;
                        end
                        n_ov = 1'b1;
                        n_state = arat_pkg::S_IDLE;
                    end
                end else if (r_i < r_cnt) begin
                    n_rv = 1'b1;
                    n_i = r_i + 1'b1;
                end else if (!r_rv) begin
                    n_ov = 1'b1;
                    n_state = arat_pkg::S_IDLE;
                end
            end
            arat_pkg::S_SHIFT: begin
                // read entry r_i, write it to r_ri (= r_i - 1) next cycle
                if (r_rv) begin
                    we = 1'b1;
                    waddr = r_ri;
                    wdata = rdata;
                end
                if (r_i < r_cnt) begin
                    n_rv = 1'b1;
                    n_i = r_i + 1'b1;
                    n_ri = r_i[IW-1:0] - 1'b1;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                    n_flag = 1'b0;
                    n_gen = r_gen + 1'b1;
                    n_ok = 1'b1;
                    n_i = '0;
                    n_state = arat_pkg::S_FLAG;
                end
            end
            arat_pkg::S_FLAG: begin
                if (r_rv && arat_pkg::touches(rs, rz, r_base, r_bytes)) begin
                    n_flag = 1'b1;
                    n_gen = r_gen + 1'b1;
                end
                if (r_i < r_cnt) begin
                    n_rv = 1'b1;
                    n_i = r_i + 1'b1;
                end else if (!r_rv) begin
                    n_ov = 1'b1;
                    n_state = arat_pkg::S_IDLE;
                end
            end
            default: n_state = arat_pkg::S_IDLE;
        endcase
    end
endmodule

@@ tb/address_range_alias_table_test.sv @@
// ----------------------------------------------------------------------------
// address_range_alias_table_test
// Streams table commands into the alias table and checks every result beat
// against a behavioral table model kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module address_range_alias_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] host_base;
        logic [31:0] length;
        logic [31:0] guest_addr;
        logic [2:0]  op;
    } t_cmd;

    typedef struct packed {
        logic [12:0] entry_count;
        logic [31:0] generation;
        logic        touches_main_mem;
        logic [31:0] ram_offset;
        logic [31:0] host_addr;
        logic        ok;
    } t_res;

    // Table model plus the queue of pending result beats.
    class alias_scoreboard;
        logic [31:0] rng_start[$];
        logic [31:0] rng_size[$];
        logic [31:0] rng_host[$];
        logic        mm_flag;
        logic [31:0] gen;
        logic [31:0] mem_base;
        logic [31:0] mem_bytes;
        t_res        pending[$];
        int          errors;

        function new();
            mem_base  = 32'h8000_0000;
            mem_bytes = 32'd25165824;
            mm_flag   = 1'b0;
            gen       = '0;
            errors    = 0;
        endfunction

        function logic hits_main(logic [31:0] s, logic [31:0] z);
            logic [32:0] e;
            logic [32:0] me;
            e  = {1'b0, s} + {1'b0, z};
            me = {1'b0, mem_base} + {1'b0, mem_bytes};
            return ({1'b0, s} < me) && (e > {1'b0, mem_base});
        endfunction

        function int find_exact(logic [31:0] s, logic [31:0] z);
            foreach (rng_start[i])
                if (rng_start[i] == s && rng_size[i] == z) return i;
            return -1;
        endfunction

        function void note_cmd(t_cmd c);
            t_res r;
            int   k;
            r = '0;
            case (c.op)
                arat_pkg::OP_RESOLVE: begin
                    if (c.length != 0) begin
                        foreach (rng_start[i]) begin
                            if (c.guest_addr < rng_start[i] || c.length > rng_size[i] ||
                                c.guest_addr - rng_start[i] > rng_size[i] - c.length)
                                continue;
                            r.ok         = 1'b1;
                            r.host_addr  = rng_host[i] + (c.guest_addr - rng_start[i]);
                            r.ram_offset = c.guest_addr - mem_base;
                            break;
                        end
                    end
                end
                arat_pkg::OP_ADD: begin
                    if (c.length != 0 && c.host_base != 0 &&
                        rng_start.size() < arat_pkg::ENTRIES) begin
                        rng_start.push_back(c.guest_addr);
                        rng_size.push_back(c.length);
                        rng_host.push_back(c.host_base);
                        if (hits_main(c.guest_addr, c.length)) begin
                            mm_flag = 1'b1;
                            gen++;
                        end
                        r.ok = 1'b1;
                    end
                end
                arat_pkg::OP_REMOVE: begin
                    k = find_exact(c.guest_addr, c.length);
                    if (k >= 0) begin
                        rng_start.delete(k);
                        rng_size.delete(k);
                        rng_host.delete(k);
                        mm_flag = 1'b0;
                        gen++;
                        foreach (rng_start[i])
                            if (hits_main(rng_start[i], rng_size[i])) begin
                                mm_flag = 1'b1;
                                gen++;
                            end
                        r.ok = 1'b1;
                    end
                end
                arat_pkg::OP_CLEAR: begin
                    rng_start.delete();
                    rng_size.delete();
                    rng_host.delete();
                    mm_flag = 1'b0;
                    gen++;
                    r.ok = 1'b1;
                end
                arat_pkg::OP_GET: begin
                    k = find_exact(c.guest_addr, c.length);
                    if (k >= 0) begin
                        r.ok        = 1'b1;
                        r.host_addr = rng_host[k];
                    end
                end
                default: ;
            endcase
            r.touches_main_mem = mm_flag;
            r.generation       = gen;
            r.entry_count      = 13'(rng_start.size());
            pending.push_back(r);
        endfunction

        function void check_beat(t_res got);
            t_res want;
            if (pending.size() == 0) begin
                $display("%0t unexpected beat: got %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.ok !== want.ok)
                $display("%0t ok: want %0d got %0d", $time, want.ok, got.ok);
            if (got.host_addr !== want.host_addr)
                $display("%0t host_addr: want %h got %h", $time, want.host_addr, got.host_addr);
            if (got.ram_offset !== want.ram_offset)
                $display("%0t ram_offset: want %h got %h", $time, want.ram_offset,
                         got.ram_offset);
            if (got.touches_main_mem !== want.touches_main_mem)
                $display("%0t touches_main_mem: want %0d got %0d", $time,
                         want.touches_main_mem, got.touches_main_mem);
            if (got.generation !== want.generation)
                $display("%0t generation: want %0d got %0d", $time, want.generation,
                         got.generation);
            if (got.entry_count !== want.entry_count)
                $display("%0t entry_count: want %0d got %0d", $time, want.entry_count,
                         got.entry_count);
            if (got !== want) errors++;
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [0:0]   i_cfg_index;
    logic [31:0]  i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata;   // op, guest_addr, length, host_base, pad
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [111:0] m_axis_tdata;   // ok, host_addr, ram_offset, touches, gen, count, pad

    alias_scoreboard table_sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  cycle_cnt;
    // Recently added ranges, so removes/gets/resolves hit often.
    logic [31:0] known_start[$];
    logic [31:0] known_size[$];

    address_range_alias_table i_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Receiver: random stall, check each accepted beat.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            table_sb.check_beat(t_res'(m_axis_tdata[110:0]));
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 3_000_000) begin
            $display("address_range_alias_table: mismatch");
            $finish;
        end
    end

    // Valid stays up after the beat; the next idle gap or drain drops it.
    task automatic send_cmd(input logic [2:0] op, input logic [31:0] ga,
                            input logic [31:0] len, input logic [31:0] hb);
        t_cmd c;
        c = '{host_base: hb, length: len, guest_addr: ga, op: op};
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, c};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        table_sb.note_cmd(c);
        if (op == arat_pkg::OP_ADD && len != 0 && hb != 0) begin
            known_start.push_back(ga);
            known_size.push_back(len);
            if (known_start.size() > 12) begin
                void'(known_start.pop_front());
                void'(known_size.pop_front());
            end
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (table_sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        if (idx == arat_pkg::REG_MEM_BASE) table_sb.mem_base = val;
        else table_sb.mem_bytes = val;
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random command biased toward recently added ranges.
    task automatic random_cmd();
        logic [2:0]  op;
        logic [31:0] ga;
        logic [31:0] len;
        logic [31:0] hb;
        int          k;
        int          pick;
        pick = $urandom_range(99);
        ga   = $urandom;
        len  = ($urandom_range(3) == 0) ? $urandom : $urandom_range(4096);
        hb   = ($urandom_range(15) == 0) ? 32'd0 : $urandom;
        if (pick < 30)      op = arat_pkg::OP_ADD;
        else if (pick < 65) op = arat_pkg::OP_RESOLVE;
        else if (pick < 78) op = arat_pkg::OP_GET;
        else if (pick < 92) op = arat_pkg::OP_REMOVE;
        else if (pick < 95) op = arat_pkg::OP_CLEAR;
        else                op = 3'($urandom_range(7));
        // Occasionally place ranges near main memory.
        if (op == arat_pkg::OP_ADD && $urandom_range(2) == 0)
            ga = table_sb.mem_base + $urandom_range(65535) - 32'd32768;
        if (op != arat_pkg::OP_ADD && known_start.size() != 0 && $urandom_range(4) != 0) begin
            k  = $urandom_range(known_start.size() - 1);
            ga = known_start[k];
            len = known_size[k];
            if (op == arat_pkg::OP_RESOLVE && len != 0) begin
                ga  = known_start[k] + $urandom_range(len - 1);
                len = $urandom_range(known_start[k] + known_size[k] - ga, 1);
                if ($urandom_range(7) == 0) len = len + 1;
            end
        end
        send_cmd(op, ga, len, hb);
    endtask

    initial begin
        table_sb      = new();
        cycle_cnt     = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, every op, rejected adds, zero-length resolve.
        send_cmd(arat_pkg::OP_RESOLVE, 32'h0, 32'h4, 32'h0);         // empty table
        send_cmd(arat_pkg::OP_ADD, 32'h1000, 32'h0, 32'h5000);       // zero size
        send_cmd(arat_pkg::OP_ADD, 32'h1000, 32'h100, 32'h0);        // zero host base
        send_cmd(arat_pkg::OP_ADD, 32'h1000, 32'h100, 32'hFFFF_FF00);
        send_cmd(arat_pkg::OP_ADD, 32'h8000_0000, 32'h10, 32'h1234); // in main memory
        send_cmd(arat_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(arat_pkg::OP_ADD, 32'h1080, 32'h100, 32'h7000);     // overlaps first
        send_cmd(arat_pkg::OP_RESOLVE, 32'h10F0, 32'h10, 32'h0);     // first wins, wraps
        send_cmd(arat_pkg::OP_RESOLVE, 32'h10F8, 32'h10, 32'h0);     // straddles: second
        send_cmd(arat_pkg::OP_RESOLVE, 32'h1010, 32'h0, 32'h0);      // zero length misses
        send_cmd(arat_pkg::OP_RESOLVE, 32'hFFFF_FFFF, 32'h1, 32'h0);
        send_cmd(arat_pkg::OP_RESOLVE, 32'h8000_000F, 32'h2, 32'h0); // runs past end
        send_cmd(arat_pkg::OP_GET, 32'h1080, 32'h100, 32'h0);
        send_cmd(arat_pkg::OP_GET, 32'h1080, 32'h101, 32'h0);
        send_cmd(arat_pkg::OP_REMOVE, 32'h1000, 32'h100, 32'h0);     // shift down
        send_cmd(arat_pkg::OP_REMOVE, 32'h1000, 32'h100, 32'h0);     // no match now
        send_cmd(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(3'd7, 32'h0, 32'h0, 32'h0);
        send_cmd(arat_pkg::OP_REMOVE, 32'h8000_0000, 32'h10, 32'h0);
        send_cmd(arat_pkg::OP_CLEAR, 32'h0, 32'h0, 32'h0);
        drain();

        // Config extremes, then random phases with changing idle mix.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    write_reg(arat_pkg::REG_MEM_BASE, 32'h0);
                    write_reg(arat_pkg::REG_MEM_BYTES, 32'hFFFF_FFFF);
                end
                1: begin
                    write_reg(arat_pkg::REG_MEM_BASE, 32'hFFFF_FFFF);
                    write_reg(arat_pkg::REG_MEM_BYTES, 32'h1);
                end
                2: begin
                    write_reg(arat_pkg::REG_MEM_BASE, $urandom);
                    write_reg(arat_pkg::REG_MEM_BYTES, $urandom);
                end
                default: begin
                    write_reg(arat_pkg::REG_MEM_BASE, 32'h8000_0000);
                    write_reg(arat_pkg::REG_MEM_BYTES, 32'd25165824);
                end
            endcase
            send_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 45 : 0;
            recv_idle_pct = (ph == 0) ? 45 : (ph == 1) ? 28 : 0;
            for (int n = 0; n < 100; n++) begin
                random_cmd();
                if (n == 50) drain();   // hold off until all results are back
            end
            drain();
        end

        if (table_sb.errors == 0 && table_sb.pending.size() == 0) begin
            $display("address_range_alias_table: match");
        end else begin
            $display("address_range_alias_table: mismatch");
        end
        $finish;
    end
endmodule
